>>> rtl/three_freq_heterodyne_unwrap_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the heterodyne unwrap block.
// ---------------------------------------------------------------------------
`ifndef THREE_FREQ_HETERODYNE_UNWRAP_DEFINES_SVH
`define THREE_FREQ_HETERODYNE_UNWRAP_DEFINES_SVH

// same-cycle implication
`define THFH_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define THFH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/thfh_pkg.sv
// ---------------------------------------------------------------------------
// thfh_pkg
// Widths, codes, types and helpers of the heterodyne unwrap pipeline.
// ---------------------------------------------------------------------------
package thfh_pkg;

  localparam int PHASE_BITS = 16;
  localparam int FREQ_BITS  = 10;
  localparam int IN_W       = 16;
  localparam int ABS_W      = 27;
  localparam int ORD_W      = 11;
  localparam int IDX_W      = 2;

  localparam int PROD_W     = FREQ_BITS + PHASE_BITS;
  localparam int T_W        = PROD_W + 1;
  localparam int O12_W      = FREQ_BITS + 2;
  localparam int A_W        = PROD_W + 2;
  localparam int M_W        = FREQ_BITS + 1 + A_W;
  localparam int N_W        = M_W + 1;
  localparam int X_W        = N_W + 1 - PHASE_BITS;
  localparam int DIV_STAGES = 4;
  localparam int DIV_STEP   = 3;
  localparam int Q_W        = DIV_STAGES * DIV_STEP;
  localparam int R_W        = FREQ_BITS + Q_W;
  localparam int FULL_W     = ORD_W + PHASE_BITS;
  localparam int CMP_W      = FULL_W + ABS_W;

  localparam int FREQ_HIGH_RST = 3;
  localparam int FREQ_MID_RST  = 2;
  localparam int FREQ_LOW_RST  = 1;

  localparam logic signed [ORD_W-1:0] ORD_MAX = ORD_W'(2 ** (ORD_W - 1) - 1);
  localparam logic signed [ORD_W-1:0] ORD_MIN = ORD_W'(-(2 ** (ORD_W - 1)));
  localparam logic [Q_W-1:0] Q_POS_LIM = Q_W'(2 ** (ORD_W - 1) - 1);
  localparam logic [Q_W-1:0] Q_NEG_LIM = Q_W'(2 ** (ORD_W - 1));
  localparam logic signed [CMP_W-1:0] ABS_MAX_X = CMP_W'(2 ** (ABS_W - 1) - 1);
  localparam logic signed [CMP_W-1:0] ABS_MIN_X = CMP_W'(-(2 ** (ABS_W - 1)));

  typedef enum logic [IDX_W-1:0] {
    REG_FREQ_HIGH = 2'd0,
    REG_FREQ_MID  = 2'd1,
    REG_FREQ_LOW  = 2'd2
  } cfg_reg_t;

  typedef logic [IN_W-1:0]              in_phase_t;
  typedef logic [PHASE_BITS-1:0]        phase_t;
  typedef logic [FREQ_BITS-1:0]         freq_t;
  typedef logic [PROD_W-1:0]            prod_t;
  typedef logic signed [A_W-1:0]        a12_t;
  typedef logic signed [M_W-1:0]        m1_t;
  typedef logic signed [N_W-1:0]        num_t;
  typedef logic [X_W-1:0]               x_t;
  typedef logic [Q_W-1:0]               quo_t;
  typedef logic [R_W-1:0]               rem_t;

  typedef struct packed {
    freq_t f1;
    freq_t f12;
    logic  ok;
  } cfg_t;

  typedef struct packed {
    logic   ok;
    logic   cerr;
    logic   neg;
    x_t     x;
    phase_t p1;
  } beat_t;

  typedef struct packed {
    logic   ok;
    logic   cerr;
    logic   neg;
    logic   ovf;
    quo_t   q;
    rem_t   r;
    phase_t p1;
  } dstage_t;

  function automatic phase_t phase_of(in_phase_t v);
    logic [PHASE_BITS+IN_W-1:0] w;
    w = {{PHASE_BITS{1'b0}}, v};
    return w[PHASE_BITS-1:0];
  endfunction

endpackage

>>> rtl/thfh_if.sv
// ---------------------------------------------------------------------------
// thfh interfaces
// Pixel, result and configuration channels with valid/ready transfer.
// ---------------------------------------------------------------------------
interface thfh_pixel_if;
  logic                  valid;
  logic                  ready;
  thfh_pkg::in_phase_t   phase_one;
  thfh_pkg::in_phase_t   phase_two;
  thfh_pkg::in_phase_t   phase_three;
  logic                  mask_one;
  logic                  mask_two;
  logic                  mask_three;

  modport source (output valid, phase_one, phase_two, phase_three,
                  mask_one, mask_two, mask_three, input ready);
  modport sink   (input valid, phase_one, phase_two, phase_three,
                  mask_one, mask_two, mask_three, output ready);
endinterface

interface thfh_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [thfh_pkg::ABS_W-1:0]  unwrap_phase;
  logic signed [thfh_pkg::ORD_W-1:0]  fine_order;
  logic                               pixel_valid;
  logic                               config_error;

  modport source (output valid, unwrap_phase, fine_order, pixel_valid,
                  config_error, input ready);
  modport sink   (input valid, unwrap_phase, fine_order, pixel_valid,
                  config_error, output ready);
endinterface

interface thfh_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [thfh_pkg::IDX_W-1:0]    index;
  thfh_pkg::freq_t               data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/three_freq_heterodyne_unwrap.sv
// ---------------------------------------------------------------------------
// three_freq_heterodyne_unwrap
// Three-frequency heterodyne phase unwrapping, one pixel per transfer.
// ---------------------------------------------------------------------------
// Usage:
//   pixel  : three wrapped phases and three masks; one transfer per cycle while ready is high.
//   result : absolute phase (16 fraction bits), fringe order, pixel_valid
//            and config_error, one result per pixel, in order.
//   cfg    : writes freq_high, freq_mid, freq_low at index 0, 1, 2; other
//            indexes are dropped. Always ready. Write only while idle.
// A result is valid once it has passed six arithmetic stages, four divider
// stages (3 quotient bits each) and the output register. One pixel per
// cycle is taken while pixel.ready is high; every stage is used once
// per pixel.
// Reset loads frequencies 3, 2, 1 and empties the pipeline.
// When the receiver stalls, the output register holds its result and only
// stages holding items stop; empty stages upstream keep filling, and
// pixel.ready falls once every stage is occupied.
// ---------------------------------------------------------------------------
`include "three_freq_heterodyne_unwrap_defines.svh"

module three_freq_heterodyne_unwrap (
  input  logic          clk,
  input  logic          rst,
  thfh_pixel_if.sink    pixel,
  thfh_result_if.source result,
  thfh_cfg_if.sink      cfg
);

  thfh_pkg::cfg_t    cfg_state;
  logic              beat_valid, beat_ready;
  thfh_pkg::beat_t   beat;
  logic              div_valid, div_ready;
  thfh_pkg::dstage_t div_q;

  logic signed [thfh_pkg::ORD_W-1:0]  ord;
  logic [thfh_pkg::FULL_W-1:0]        full;
  logic signed [thfh_pkg::CMP_W-1:0]  wide;
  logic signed [thfh_pkg::CMP_W-1:0]  clamped;
  logic                               fin_en;

  thfh_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .state (cfg_state)
  );

  thfh_beat u_beat (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pixel),
    .cfgs      (cfg_state),
    .out_valid (beat_valid),
    .out_ready (beat_ready),
    .beat      (beat)
  );

  thfh_div u_div (
    .clk       (clk),
    .rst       (rst),
    .f12       (cfg_state.f12),
    .in_valid  (beat_valid),
    .in_ready  (beat_ready),
    .in_beat   (beat),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_q     (div_q)
  );

  assign fin_en    = !result.valid || result.ready;
  assign div_ready = fin_en;

  always_comb begin
    if (div_q.neg) begin
      if (div_q.ovf || (div_q.q > thfh_pkg::Q_NEG_LIM)) begin
        ord = thfh_pkg::ORD_MIN;
      end else begin
        ord = -$signed(div_q.q[thfh_pkg::ORD_W-1:0]);
      end
    end else begin
      if (div_q.ovf || (div_q.q > thfh_pkg::Q_POS_LIM)) begin
        ord = thfh_pkg::ORD_MAX;
      end else begin
        ord = $signed(div_q.q[thfh_pkg::ORD_W-1:0]);
      end
    end
  end

  assign full = {ord, div_q.p1};
  assign wide = $signed({{thfh_pkg::ABS_W{full[thfh_pkg::FULL_W-1]}}, full});

  always_comb begin
    if (wide > thfh_pkg::ABS_MAX_X) begin
      clamped = thfh_pkg::ABS_MAX_X;
    end else if (wide < thfh_pkg::ABS_MIN_X) begin
      clamped = thfh_pkg::ABS_MIN_X;
    end else begin
      clamped = wide;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (fin_en) begin
      result.valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_en) begin
      result.unwrap_phase <= div_q.ok ? clamped[thfh_pkg::ABS_W-1:0] : '0;
      result.fine_order   <= div_q.ok ? ord : '0;
      result.pixel_valid  <= div_q.ok;
      result.config_error <= div_q.cerr;
    end
  end

  `THFH_ASSERT_IMPLY(a_stall_only_from_sink, clk, rst, !pixel.ready, result.valid && !result.ready, "pixel stalled without a held result")
  `THFH_ASSERT_NEXT(a_beat_held, clk, rst, beat_valid && !beat_ready, beat_valid && $stable(beat), "front end item lost during stall")
  `THFH_ASSERT_NEXT(a_ovf_saturates, clk, rst, div_valid && div_ready && div_q.ok && div_q.ovf, result.fine_order == thfh_pkg::ORD_MAX || result.fine_order == thfh_pkg::ORD_MIN, "quotient overflow not saturated")

endmodule

>>> rtl/thfh_cfg.sv
// ---------------------------------------------------------------------------
// thfh_cfg
// Frequency registers and the ordering / beat-one consistency check.
// ---------------------------------------------------------------------------
module thfh_cfg (
  input  logic             clk,
  input  logic             rst,
  thfh_cfg_if.sink         cfg,
  output thfh_pkg::cfg_t   state
);

  thfh_pkg::freq_t freq_high;
  thfh_pkg::freq_t freq_mid;
  thfh_pkg::freq_t freq_low;
  logic [thfh_pkg::FREQ_BITS+1:0] sum_outer;
  logic [thfh_pkg::FREQ_BITS+1:0] sum_mid;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      freq_high <= thfh_pkg::freq_t'(thfh_pkg::FREQ_HIGH_RST);
      freq_mid  <= thfh_pkg::freq_t'(thfh_pkg::FREQ_MID_RST);
      freq_low  <= thfh_pkg::freq_t'(thfh_pkg::FREQ_LOW_RST);
    end else if (cfg.valid && cfg.ready) begin
      unique case (thfh_pkg::cfg_reg_t'(cfg.index))
        thfh_pkg::REG_FREQ_HIGH: freq_high <= cfg.data;
        thfh_pkg::REG_FREQ_MID:  freq_mid  <= cfg.data;
        thfh_pkg::REG_FREQ_LOW:  freq_low  <= cfg.data;
        default: ;
      endcase
    end
  end

  // f1 - f2 - (f2 - f3) == 1  <=>  f1 + f3 == 2*f2 + 1
  assign sum_outer = {2'b00, freq_high} + {2'b00, freq_low};
  assign sum_mid   = {1'b0, freq_mid, 1'b0} + {{(thfh_pkg::FREQ_BITS+1){1'b0}}, 1'b1};

  assign state.ok  = (freq_high > freq_mid) && (freq_mid > freq_low) &&
                     (freq_low != '0) && (sum_outer == sum_mid);
  assign state.f1  = freq_high;
  assign state.f12 = freq_high - freq_mid;

endmodule

>>> rtl/thfh_beat.sv
// ---------------------------------------------------------------------------
// thfh_beat
// Six-stage front end: beat phases, beat order, scaled numerator and the
// rounded dividend for the fringe order.
// ---------------------------------------------------------------------------
module thfh_beat (
  input  logic             clk,
  input  logic             rst,
  thfh_pixel_if.sink       pixel,
  input  thfh_pkg::cfg_t   cfgs,
  output logic             out_valid,
  input  logic             out_ready,
  output thfh_pkg::beat_t  beat
);

  logic [5:0] v;
  logic [6:0] en;
  logic [5:0] vin;

  thfh_pkg::phase_t p1, p2, p3, p12_c, pc_c;

  thfh_pkg::phase_t s1_p1, s1_p12, s1_pc;
  logic             s1_ok, s1_cerr;

  thfh_pkg::prod_t  s2_prod;
  thfh_pkg::phase_t s2_p1, s2_p12;
  logic             s2_ok, s2_cerr;

  logic signed [thfh_pkg::T_W-1:0]   t;
  logic [thfh_pkg::T_W-1:0]          t_mag;
  logic [thfh_pkg::T_W:0]            t_rnd;
  logic [thfh_pkg::FREQ_BITS:0]      q12;
  logic signed [thfh_pkg::O12_W-1:0] order12;
  thfh_pkg::a12_t                    a12_c;

  thfh_pkg::a12_t   s3_a12;
  thfh_pkg::prod_t  s3_pp1;
  thfh_pkg::phase_t s3_p1;
  logic             s3_ok, s3_cerr;

  thfh_pkg::m1_t    s4_m1;
  thfh_pkg::prod_t  s4_pp1;
  thfh_pkg::phase_t s4_p1;
  logic             s4_ok, s4_cerr;

  thfh_pkg::num_t   s5_n;
  thfh_pkg::phase_t s5_p1;
  logic             s5_ok, s5_cerr;

  logic [thfh_pkg::N_W-1:0] n_mag;
  logic [thfh_pkg::N_W+1:0] x_sum;

  assign en[6] = out_ready;
  for (genvar k = 0; k < 6; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end
  assign vin         = {v[4:0], pixel.valid};
  assign pixel.ready = en[0];
  assign out_valid   = v[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= (en[5:0] & vin) | (~en[5:0] & v);
    end
  end

  // stage 1: beat and coarse phases
  assign p1    = thfh_pkg::phase_of(pixel.phase_one);
  assign p2    = thfh_pkg::phase_of(pixel.phase_two);
  assign p3    = thfh_pkg::phase_of(pixel.phase_three);
  assign p12_c = p1 - p2;
  assign pc_c  = p12_c - (p2 - p3);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_p1   <= p1;
      s1_p12  <= p12_c;
      s1_pc   <= pc_c;
      s1_ok   <= cfgs.ok && pixel.mask_one && pixel.mask_two && pixel.mask_three;
      s1_cerr <= !cfgs.ok;
    end
  end

  // stage 2: f12 * coarse phase
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_prod <= cfgs.f12 * s1_pc;
      s2_p1   <= s1_p1;
      s2_p12  <= s1_p12;
      s2_ok   <= s1_ok;
      s2_cerr <= s1_cerr;
    end
  end

  // stage 3: beat order, absolute beat phase, f12 * p1
  assign t = $signed({1'b0, s2_prod}) -
             $signed({{(thfh_pkg::FREQ_BITS+1){1'b0}}, s2_p12});
  assign t_mag = t[thfh_pkg::T_W-1] ? $unsigned(-t) : $unsigned(t);
  assign t_rnd = {t_mag, 1'b0} + ((thfh_pkg::T_W+1)'(1) << thfh_pkg::PHASE_BITS);
  assign q12   = t_rnd[thfh_pkg::T_W:thfh_pkg::PHASE_BITS+1];
  assign order12 = t[thfh_pkg::T_W-1] ? -$signed({1'b0, q12}) : $signed({1'b0, q12});
  assign a12_c = $signed({order12, {thfh_pkg::PHASE_BITS{1'b0}}}) +
                 $signed({{(thfh_pkg::FREQ_BITS+2){1'b0}}, s2_p12});

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_a12  <= a12_c;
      s3_pp1  <= cfgs.f12 * s2_p1;
      s3_p1   <= s2_p1;
      s3_ok   <= s2_ok;
      s3_cerr <= s2_cerr;
    end
  end

  // stage 4: f1 * absolute beat phase
  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_m1   <= $signed({1'b0, cfgs.f1}) * s3_a12;
      s4_pp1  <= s3_pp1;
      s4_p1   <= s3_p1;
      s4_ok   <= s3_ok;
      s4_cerr <= s3_cerr;
    end
  end

  // stage 5: numerator
  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_n    <= $signed({s4_m1[thfh_pkg::M_W-1], s4_m1}) -
                 $signed({{(thfh_pkg::N_W-thfh_pkg::PROD_W){1'b0}}, s4_pp1});
      s5_p1   <= s4_p1;
      s5_ok   <= s4_ok;
      s5_cerr <= s4_cerr;
    end
  end

  // stage 6: fold the rounding into the dividend
  assign n_mag = s5_n[thfh_pkg::N_W-1] ? $unsigned(-s5_n) : $unsigned(s5_n);
  assign x_sum = {1'b0, n_mag, 1'b0} +
                 ((thfh_pkg::N_W+2)'(cfgs.f12) << thfh_pkg::PHASE_BITS);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      beat.ok   <= s5_ok;
      beat.cerr <= s5_cerr;
      beat.neg  <= s5_n[thfh_pkg::N_W-1];
      beat.x    <= x_sum[thfh_pkg::N_W+1:thfh_pkg::PHASE_BITS+1];
      beat.p1   <= s5_p1;
    end
  end

endmodule

>>> rtl/thfh_div.sv
// ---------------------------------------------------------------------------
// thfh_div
// Pipelined restoring divider by f12 with an overflow flag for quotients
// that cannot fit the quotient width.
// ---------------------------------------------------------------------------
module thfh_div (
  input  logic               clk,
  input  logic               rst,
  input  thfh_pkg::freq_t    f12,
  input  logic               in_valid,
  output logic               in_ready,
  input  thfh_pkg::beat_t    in_beat,
  output logic               out_valid,
  input  logic               out_ready,
  output thfh_pkg::dstage_t  out_q
);

  logic [thfh_pkg::DIV_STAGES-1:0] v;
  logic [thfh_pkg::DIV_STAGES:0]   en;
  logic [thfh_pkg::DIV_STAGES-1:0] vin;

  thfh_pkg::dstage_t st      [thfh_pkg::DIV_STAGES];
  thfh_pkg::dstage_t st_next [thfh_pkg::DIV_STAGES];
  thfh_pkg::dstage_t src     [thfh_pkg::DIV_STAGES];

  logic [thfh_pkg::X_W+thfh_pkg::R_W-1:0] xw;
  logic [thfh_pkg::X_W+thfh_pkg::R_W-1:0] lim;

  assign en[thfh_pkg::DIV_STAGES] = out_ready;
  for (genvar k = 0; k < thfh_pkg::DIV_STAGES; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end
  assign vin       = {v[thfh_pkg::DIV_STAGES-2:0], in_valid};
  assign in_ready  = en[0];
  assign out_valid = v[thfh_pkg::DIV_STAGES-1];
  assign out_q     = st[thfh_pkg::DIV_STAGES-1];

  assign xw  = {{thfh_pkg::R_W{1'b0}}, in_beat.x};
  assign lim = {{thfh_pkg::X_W{1'b0}}, f12, {thfh_pkg::Q_W{1'b0}}};

  assign src[0].ok   = in_beat.ok;
  assign src[0].cerr = in_beat.cerr;
  assign src[0].neg  = in_beat.neg;
  assign src[0].ovf  = xw >= lim;
  assign src[0].q    = '0;
  assign src[0].r    = xw[thfh_pkg::R_W-1:0];
  assign src[0].p1   = in_beat.p1;

  for (genvar k = 1; k < thfh_pkg::DIV_STAGES; k++) begin : g_src
    assign src[k] = st[k-1];
  end

  always_comb begin : div_steps
    thfh_pkg::dstage_t cur;
    thfh_pkg::rem_t    dd;
    int                b;
    for (int k = 0; k < thfh_pkg::DIV_STAGES; k++) begin
      cur = src[k];
      for (int j = 0; j < thfh_pkg::DIV_STEP; j++) begin
        b  = thfh_pkg::Q_W - 1 - (k * thfh_pkg::DIV_STEP + j);
        dd = thfh_pkg::rem_t'(f12) << b;
        if (cur.r >= dd) begin
          cur.r    = cur.r - dd;
          cur.q[b] = 1'b1;
        end
      end
      st_next[k] = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= (en[thfh_pkg::DIV_STAGES-1:0] & vin) | (~en[thfh_pkg::DIV_STAGES-1:0] & v);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < thfh_pkg::DIV_STAGES; k++) begin
      if (en[k]) begin
        st[k] <= st_next[k];
      end
    end
  end

endmodule

>>> sim/tb_three_freq_heterodyne_unwrap.sv
// ---------------------------------------------------------------------------
// tb_three_freq_heterodyne_unwrap
// Streams pixels through the heterodyne unwrap block under many frequency
// settings (legal, illegal and at the range limits), predicts absolute phase,
// fringe order and flags per pixel, and checks each result in order while
// the sender idles and the receiver stalls at random.
// ---------------------------------------------------------------------------
module tb_three_freq_heterodyne_unwrap;
  import thfh_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
  localparam longint PH_ONE   = longint'(1) <<< PHASE_BITS;
  localparam longint PH_MASK  = PH_ONE - 1;
  localparam longint ABS_HI   = (longint'(1) <<< (ABS_W - 1)) - 1;
  localparam longint ABS_LO   = -(longint'(1) <<< (ABS_W - 1));
  localparam int     IDLE_PCT = 28;

  typedef struct {
    in_phase_t ph1;
    in_phase_t ph2;
    in_phase_t ph3;
    logic      m1;
    logic      m2;
    logic      m3;
  } pixel_t;

  typedef struct {
    logic signed [ABS_W-1:0] abs_ph;
    logic signed [ORD_W-1:0] order;
    logic                    ok;
    logic                    cerr;
  } unwrap_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  thfh_pixel_if  pix_if ();
  thfh_result_if res_if ();
  thfh_cfg_if    cfg_if ();

  three_freq_heterodyne_unwrap u_dut (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pix_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  freq_t freq_hi = freq_t'(FREQ_HIGH_RST);
  freq_t freq_md = freq_t'(FREQ_MID_RST);
  freq_t freq_lo = freq_t'(FREQ_LOW_RST);

  unwrap_res_t pending_q[$];
  unwrap_res_t want;

  bit src_idle_on = 1'b1;
  bit snk_idle_on = 1'b1;
  int stall_left  = 0;
  int err_cnt     = 0;
  int res_cnt     = 0;
  int n_pix       = 0;
  int n_set       = 0;
  int n_ok        = 0;
  int n_masked    = 0;
  int n_cerr      = 0;
  int n_sat       = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #(400000 * 12);
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint div_round(longint n, longint d);
    longint a;
    longint q;
    a = (n < 0) ? -n : n;
    q = (2 * a + d) / (2 * d);
    return (n < 0) ? -q : q;
  endfunction

  function automatic unwrap_res_t unwrap_pixel(pixel_t px);
    longint f1, f2, f3, f12;
    longint p1, p2, p3, p12, p23, pc;
    longint o12, a12, o1, ab;
    logic cfg_ok;
    unwrap_res_t r;
    f1 = longint'(freq_hi);
    f2 = longint'(freq_md);
    f3 = longint'(freq_lo);
    cfg_ok = (f1 > f2) && (f2 > f3) && (f3 > 0) && ((f1 - f2) - (f2 - f3) == 1);
    r.abs_ph = '0;
    r.order  = '0;
    r.ok     = cfg_ok && px.m1 && px.m2 && px.m3;
    r.cerr   = !cfg_ok;
    if (r.ok) begin
      p1  = longint'(px.ph1) & PH_MASK;
      p2  = longint'(px.ph2) & PH_MASK;
      p3  = longint'(px.ph3) & PH_MASK;
      f12 = f1 - f2;
      p12 = (p1 - p2) & PH_MASK;
      p23 = (p2 - p3) & PH_MASK;
      pc  = (p12 - p23) & PH_MASK;
      o12 = div_round(f12 * pc - p12, PH_ONE);
      a12 = p12 + o12 * PH_ONE;
      o1  = div_round(f1 * a12 - f12 * p1, f12 * PH_ONE);
      if (o1 < longint'(ORD_MIN)) o1 = longint'(ORD_MIN);
      if (o1 > longint'(ORD_MAX)) o1 = longint'(ORD_MAX);
      ab = p1 + o1 * PH_ONE;
      if (ab < ABS_LO) ab = ABS_LO;
      if (ab > ABS_HI) ab = ABS_HI;
      r.abs_ph = ABS_W'(ab);
      r.order  = ORD_W'(o1);
    end
    return r;
  endfunction

  function automatic pixel_t mk_pixel(in_phase_t a, in_phase_t b, in_phase_t c,
                                      logic [2:0] m);
    pixel_t px;
    px.ph1 = a;
    px.ph2 = b;
    px.ph3 = c;
    px.m1  = m[2];
    px.m2  = m[1];
    px.m3  = m[0];
    return px;
  endfunction

  function automatic pixel_t rand_pixel();
    in_phase_t corner_vals[4];
    pixel_t px;
    int unsigned sel;
    longint t;
    logic [2:0] m;
    corner_vals = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF};
    sel = $urandom_range(99);
    if (sel < 50) begin
      // phases of one surface point, with a little noise
      t = longint'($urandom_range(0, 65535));
      px.ph1 = in_phase_t'(longint'(freq_hi) * t + int'($urandom_range(0, 64)) - 32);
      px.ph2 = in_phase_t'(longint'(freq_md) * t + int'($urandom_range(0, 64)) - 32);
      px.ph3 = in_phase_t'(longint'(freq_lo) * t + int'($urandom_range(0, 64)) - 32);
    end else if (sel < 60) begin
      px.ph1 = corner_vals[$urandom_range(3)];
      px.ph2 = corner_vals[$urandom_range(3)];
      px.ph3 = corner_vals[$urandom_range(3)];
    end else begin
      px.ph1 = in_phase_t'($urandom());
      px.ph2 = in_phase_t'($urandom());
      px.ph3 = in_phase_t'($urandom());
    end
    m = ($urandom_range(99) < 85) ? 3'b111 : 3'($urandom_range(7));
    px.m1 = m[2];
    px.m2 = m[1];
    px.m3 = m[0];
    return px;
  endfunction

  task automatic report_mismatch(input string what);
    err_cnt++;
    $display("ERROR at %0t, result %0d: %s", $time, res_cnt, what);
  endtask

  task automatic send_pixel(input pixel_t px);
    unwrap_res_t e;
    @(negedge clk);
    while (src_idle_on && $urandom_range(99) < IDLE_PCT) begin
      pix_if.valid <= 1'b0;
      @(negedge clk);
    end
    pix_if.valid       <= 1'b1;
    pix_if.phase_one   <= px.ph1;
    pix_if.phase_two   <= px.ph2;
    pix_if.phase_three <= px.ph3;
    pix_if.mask_one    <= px.m1;
    pix_if.mask_two    <= px.m2;
    pix_if.mask_three  <= px.m3;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    e = unwrap_pixel(px);
    pending_q.push_back(e);
    n_pix++;
    if (e.cerr) n_cerr++;
    else if (!e.ok) n_masked++;
    else n_ok++;
    if (e.ok && e.order == ORD_MAX) n_sat++;
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    pix_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input freq_t val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_FREQ_HIGH: freq_hi = val;
      REG_FREQ_MID:  freq_md = val;
      REG_FREQ_LOW:  freq_lo = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic apply_freqs(input freq_t f1, input freq_t f2, input freq_t f3);
    write_reg(REG_FREQ_HIGH, f1);
    write_reg(REG_FREQ_MID, f2);
    write_reg(REG_FREQ_LOW, f3);
    n_set++;
  endtask

  // result side: random or held-off ready
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else if (snk_idle_on) begin
        res_if.ready <= ($urandom_range(99) >= IDLE_PCT);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("result transfer with no pixel pending");
      end else begin
        want = pending_q.pop_front();
        if (res_if.unwrap_phase !== want.abs_ph)
          report_mismatch($sformatf("unwrap_phase got %0d want %0d",
                                    res_if.unwrap_phase, want.abs_ph));
        if (res_if.fine_order !== want.order)
          report_mismatch($sformatf("fine_order got %0d want %0d",
                                    res_if.fine_order, want.order));
        if (res_if.pixel_valid !== want.ok)
          report_mismatch($sformatf("pixel_valid got %b want %b",
                                    res_if.pixel_valid, want.ok));
        if (res_if.config_error !== want.cerr)
          report_mismatch($sformatf("config_error got %b want %b",
                                    res_if.config_error, want.cerr));
      end
      res_cnt++;
    end
  end

  task automatic test_reset_config();
    // 3, 2, 1 breaks the beat-one rule
    send_pixel(mk_pixel(16'h4000, 16'h2000, 16'h1000, 3'b111));
    send_pixel(mk_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b011));
    send_pixel(mk_pixel(16'h0000, 16'h0000, 16'h0000, 3'b000));
    wait_for_results();
  endtask

  task automatic test_mask_combos();
    int m;
    apply_freqs(10'd4, 10'd2, 10'd1);
    for (m = 0; m < 8; m++)
      send_pixel(mk_pixel(in_phase_t'(16'h2345 * (m + 1)), in_phase_t'(16'h1111 * m),
                          in_phase_t'(16'hF00D - 16'h0123 * m), 3'(m)));
    send_pixel(mk_pixel(16'h0000, 16'h0000, 16'h0000, 3'b111));
    send_pixel(mk_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b111));
    send_pixel(mk_pixel(16'hFFFF, 16'h0000, 16'h0000, 3'b111));
    send_pixel(mk_pixel(16'h0000, 16'hFFFF, 16'h0000, 3'b111));
    send_pixel(mk_pixel(16'h0000, 16'h0000, 16'hFFFF, 3'b111));
    // coarse order of minus one
    send_pixel(mk_pixel(16'hFFFF, 16'h0000, 16'h0001, 3'b111));
    wait_for_results();
  endtask

  task automatic test_config_extremes();
    apply_freqs(10'd1023, 10'd1021, 10'd1020);
    // beat order rounds up from one half, fringe order saturates high
    send_pixel(mk_pixel(16'd32766, 16'd0, 16'd32769, 3'b111));
    send_pixel(mk_pixel(16'h8001, 16'h7FFE, 16'hC000, 3'b111));
    wait_for_results();
    apply_freqs(10'd1023, 10'd512, 10'd2);
    write_reg(REG_SPARE, 10'd5);
    send_pixel(mk_pixel(16'hABCD, 16'h1357, 16'h2468, 3'b111));
    wait_for_results();
    apply_freqs(10'd1023, 10'd1022, 10'd1021);
    send_pixel(mk_pixel(16'h1000, 16'h2000, 16'h3000, 3'b111));
    wait_for_results();
    apply_freqs(10'd3, 10'd1, 10'd0);
    send_pixel(mk_pixel(16'h1000, 16'h2000, 16'h3000, 3'b101));
    wait_for_results();
    apply_freqs(10'd1, 10'd2, 10'd4);
    send_pixel(mk_pixel(16'h7777, 16'h8888, 16'h9999, 3'b111));
    wait_for_results();
  endtask

  task automatic test_random_settings();
    int k;
    int unsigned d;
    int unsigned f3;
    for (k = 0; k < 12; k++) begin
      if (k == 0) begin
        apply_freqs(10'd4, 10'd2, 10'd1);
      end else if (k == 1) begin
        apply_freqs(10'd1023, 10'd1021, 10'd1020);
      end else if (k == 2) begin
        apply_freqs(10'd1023, 10'd512, 10'd2);
      end else if ($urandom_range(99) < 70) begin
        d  = $urandom_range(1, 510);
        f3 = $urandom_range(1, 1022 - 2 * d);
        apply_freqs(freq_t'(f3 + 2 * d + 1), freq_t'(f3 + d), freq_t'(f3));
      end else begin
        apply_freqs(freq_t'($urandom_range(1023)), freq_t'($urandom_range(1023)),
                    freq_t'($urandom_range(1023)));
      end
      repeat (100) send_pixel(rand_pixel());
      wait_for_results();
    end
  endtask

  task automatic test_output_stall();
    apply_freqs(10'd1023, 10'd1021, 10'd1020);
    src_idle_on = 1'b0;
    stall_left  = 300;
    repeat (120) send_pixel(rand_pixel());
    src_idle_on = 1'b1;
    wait_for_results();
  endtask

  task automatic test_sender_pause();
    apply_freqs(10'd70, 10'd64, 10'd59);
    repeat (40) send_pixel(rand_pixel());
    wait_for_results();
    repeat (40) send_pixel(rand_pixel());
    wait_for_results();
  endtask

  task automatic test_no_idle();
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    repeat (200) send_pixel(rand_pixel());
    wait_for_results();
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
  endtask

  initial begin
    pix_if.valid       = 1'b0;
    pix_if.phase_one   = '0;
    pix_if.phase_two   = '0;
    pix_if.phase_three = '0;
    pix_if.mask_one    = 1'b0;
    pix_if.mask_two    = 1'b0;
    pix_if.mask_three  = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;
    rst                = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_config();
    test_mask_combos();
    test_config_extremes();
    test_random_settings();
    test_output_stall();
    test_sender_pause();
    test_no_idle();

    wait_for_results();
    repeat (24) @(posedge clk);
    $display("Ran %0d pixels, %0d settings: %0d unwrapped, %0d masked, %0d bad config",
             n_pix, n_set, n_ok, n_masked, n_cerr);
    $display("Fringe order clipped on %0d pixels; long output hold-off and sender pauses done",
             n_sat);
    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/thfh_pkg.sv
rtl/thfh_if.sv
rtl/thfh_cfg.sv
rtl/thfh_beat.sv
rtl/thfh_div.sv
rtl/three_freq_heterodyne_unwrap.sv
sim/tb_three_freq_heterodyne_unwrap.sv
